FILE: rtl/cmit_pkg.sv
// Constants and address decode shared by the mapper IRQ timer.
`timescale 1ns / 1ps
`default_nettype none

package cmit_pkg;

    localparam int unsigned SEL_W = 5;
    localparam int unsigned NUM_DEC = 17;

    localparam logic [SEL_W-1:0] SEL_LATCH   = 5'd14;
    localparam logic [SEL_W-1:0] SEL_CONTROL = 5'd15;
    localparam logic [SEL_W-1:0] SEL_ACK     = 5'd16;
    localparam logic [SEL_W-1:0] SEL_NONE    = 5'd17;

    localparam logic [1:0] VARIANT_REV_A = 2'd0;
    localparam logic [1:0] VARIANT_REV_B = 2'd1;

    localparam logic       ACTION_TICK  = 1'b0;
    localparam logic       ACTION_WRITE = 1'b1;

    localparam logic [8:0] PRESCALE_LIMIT = 9'd338;
    localparam logic [8:0] PRESCALE_STEP  = 9'd3;
    localparam logic [8:0] PRESCALE_MAX   = 9'd340;

    localparam logic [7:0] WRAP_LICENSED   = 8'hFF;
    localparam logic [7:0] WRAP_UNLICENSED = 8'hF7;

    localparam logic [15:0] MASK_REV_B = 16'hF000;
    localparam logic [15:0] MASK_REV_A = 16'hF020;
    localparam logic [15:0] ADDR_UNL_HOLE = 16'h9001;

    localparam logic [15:0] DEC_ADDR [NUM_DEC] = '{
        16'h8000, 16'h8001, 16'h9000, 16'h9001, 16'h9021, 16'hA000,
        16'hA001, 16'hB000, 16'hB001, 16'hC000, 16'hC001, 16'hD000,
        16'hD001, 16'hE000, 16'hE001, 16'hF000, 16'hF001
    };

    // Map a CPU write address to a register number for the given board variant.
    function automatic logic [SEL_W-1:0] decode_addr(input logic [15:0] addr,
                                                     input logic [1:0]  variant);
        logic [15:0]      d;
        logic [SEL_W-1:0] sel;
        logic             hole;
        sel  = SEL_NONE;
        hole = 1'b0;
        if (variant[1])
        begin
            d    = (addr & MASK_REV_B) | {15'd0, addr[3]};
            hole = (d == ADDR_UNL_HOLE);
        end
        else if (variant == VARIANT_REV_A)
        begin
            d = (addr & MASK_REV_A) | {14'd0, addr[3], addr[4]};
        end
        else
        begin
            d = (addr & MASK_REV_B) | {14'd0, addr[4], addr[3]};
        end
        for (int k = 0; k < NUM_DEC; k++)
        begin
            if (DEC_ADDR[k] == d)
            begin
                sel = SEL_W'(k);
            end
        end
        if (hole)
        begin
            sel = SEL_NONE;
        end
        return sel;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cartridge_mapper_irq_timer.sv
// Mapper IRQ timer: address decode per board variant and cycle/prescaled IRQ counter.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------
//  input    | in_valid / in_ready   | action, address, value
//  result   | out_valid / out_ready | irq_line, reg_select, reg_data
//  config   | cfg_we                | cfg_data (board_variant)
//
// One item per clock sustained while out_ready holds; an item passes the input register, then the result register.
// Counter, prescaler and IRQ state update when an item leaves the input register.
// A stalled result holds both registers; in_ready follows the result slot.
// Reset clears all timer state; board_variant resets to revision B.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_mapper_irq_timer
    import cmit_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             action,
    input  wire logic [15:0]      address,
    input  wire logic [7:0]       value,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  irq_line,
    output logic [SEL_W-1:0]      reg_select,
    output logic [7:0]            reg_data,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_data
);

    logic [1:0]       variant_reg;

    logic             s0_valid_reg;
    logic             s0_action_reg;
    logic [15:0]      s0_address_reg;
    logic [7:0]       s0_value_reg;

    logic             out_valid_reg;
    logic             irq_line_reg;
    logic [SEL_W-1:0] reg_select_reg;
    logic [7:0]       reg_data_reg;

    logic             irq_enabled_reg, irq_enabled_next;
    logic             enable_after_ack_reg, enable_after_ack_next;
    logic             count_every_cycle_reg, count_every_cycle_next;
    logic [7:0]       reload_latch_reg, reload_latch_next;
    logic [7:0]       irq_counter_reg, irq_counter_next;
    logic [8:0]       prescaler_reg, prescaler_next;
    logic             pending_delay_reg, pending_delay_next;
    logic             irq_flag_reg, irq_flag_next;

    logic             s0_go;
    logic [SEL_W-1:0] sel;
    logic [7:0]       wrap;

    assign s0_go    = s0_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s0_valid_reg || s0_go;

    assign sel  = (s0_action_reg == ACTION_WRITE) ? decode_addr(s0_address_reg, variant_reg)
                                                  : SEL_NONE;
    assign wrap = variant_reg[1] ? WRAP_UNLICENSED : WRAP_LICENSED;

    always_comb
    begin
        irq_enabled_next       = irq_enabled_reg;
        enable_after_ack_next  = enable_after_ack_reg;
        count_every_cycle_next = count_every_cycle_reg;
        reload_latch_next      = reload_latch_reg;
        irq_counter_next       = irq_counter_reg;
        prescaler_next         = prescaler_reg;
        pending_delay_next     = pending_delay_reg;
        irq_flag_next          = irq_flag_reg;
        if (s0_action_reg == ACTION_TICK)
        begin
            if (pending_delay_reg)
            begin
                pending_delay_next = 1'b0;
                irq_flag_next      = 1'b1;
            end
            if (irq_enabled_reg)
            begin
                if (!count_every_cycle_reg && (prescaler_reg < PRESCALE_LIMIT))
                begin
                    prescaler_next = prescaler_reg + PRESCALE_STEP;
                end
                else
                begin
                    if (!count_every_cycle_reg)
                    begin
                        prescaler_next = prescaler_reg - PRESCALE_LIMIT;
                    end
                    if (irq_counter_reg != wrap)
                    begin
                        irq_counter_next = irq_counter_reg + 8'd1;
                    end
                    else
                    begin
                        irq_counter_next   = reload_latch_reg;
                        pending_delay_next = 1'b1;
                    end
                end
            end
        end
        else
        begin
            priority if (sel == SEL_LATCH)
            begin
                reload_latch_next = s0_value_reg;
            end
            else if (sel == SEL_CONTROL)
            begin
                enable_after_ack_next  = s0_value_reg[0];
                irq_enabled_next       = s0_value_reg[1];
                count_every_cycle_next = s0_value_reg[2];
                if (s0_value_reg[1])
                begin
                    prescaler_next   = '0;
                    irq_counter_next = reload_latch_reg;
                end
                irq_flag_next = 1'b0;
            end
            else if (sel == SEL_ACK)
            begin
                irq_enabled_next = enable_after_ack_reg;
                irq_flag_next    = 1'b0;
            end
            else
            begin
                irq_flag_next = irq_flag_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg           <= VARIANT_REV_B;
            s0_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            irq_enabled_reg       <= 1'b0;
            enable_after_ack_reg  <= 1'b0;
            count_every_cycle_reg <= 1'b0;
            reload_latch_reg      <= '0;
            irq_counter_reg       <= '0;
            prescaler_reg         <= '0;
            pending_delay_reg     <= 1'b0;
            irq_flag_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                variant_reg <= cfg_data;
            end
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s0_go)
            begin
                out_valid_reg         <= 1'b1;
                irq_enabled_reg       <= irq_enabled_next;
                enable_after_ack_reg  <= enable_after_ack_next;
                count_every_cycle_reg <= count_every_cycle_next;
                reload_latch_reg      <= reload_latch_next;
                irq_counter_reg       <= irq_counter_next;
                prescaler_reg         <= prescaler_next;
                pending_delay_reg     <= pending_delay_next;
                irq_flag_reg          <= irq_flag_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s0_action_reg  <= action;
            s0_address_reg <= address;
            s0_value_reg   <= value;
        end
        if (s0_go)
        begin
            irq_line_reg   <= irq_flag_next;
            reg_select_reg <= sel;
            reg_data_reg   <= (sel == SEL_NONE) ? 8'd0 : s0_value_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign irq_line   = irq_line_reg;
    assign reg_select = reg_select_reg;
    assign reg_data   = reg_data_reg;

    a_pending_raises: assert property (@(posedge clk) disable iff (!rst_n)
        s0_go && (s0_action_reg == ACTION_TICK) && pending_delay_reg |=> irq_flag_reg)
        else $error("pending reload did not raise irq");

    a_control_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s0_go && (s0_action_reg == ACTION_WRITE) && (sel == SEL_CONTROL) |=> !irq_flag_reg)
        else $error("control write left irq set");

    a_prescaler_range: assert property (@(posedge clk) disable iff (!rst_n)
        prescaler_reg <= PRESCALE_MAX)
        else $error("prescaler out of range");

    a_none_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (reg_select_reg == SEL_NONE) |-> (reg_data_reg == 8'd0))
        else $error("data reported without a decoded register");

endmodule

`default_nettype wire
